// ===== sv/prr_pkg.sv =====
// Package: shared types and constants for the polyphase rational resampler.
`timescale 1ns / 1ps
`default_nettype none
package prr_pkg;
	localparam int MAX_UP        = 64;
	localparam int HIST_DEPTH    = 256;
	localparam int HIST_AW       = 8;
	localparam int COEF_DEPTH    = 4096;
	localparam int COEF_AW       = 12;
	localparam int COEF_WIDTH    = 24;
	localparam int SAMPLE_WIDTH  = 32;
	localparam int ACC_WIDTH     = 64;
	localparam int FRAC_BITS     = 23;

	localparam logic [1:0] REG_UP   = 2'd0;
	localparam logic [1:0] REG_DOWN = 2'd1;
	localparam logic [1:0] REG_TAPS = 2'd2;
	localparam logic [1:0] REG_SKIP = 2'd3;

	typedef struct packed {
		logic       coef_wr;
		logic       hist_wr;
		logic       start;
		logic       issue;
		logic       fin_mag;
		logic       fin_scale;
		logic       load_out;
		logic       out_last;
		logic [7:0] phase;
		logic [6:0] ell;
	} prr_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} prr_stat_t;
endpackage
`default_nettype wire

// ===== sv/polyphase_rational_resampler.sv =====
// Each output phase runs MAC, drain, magnitude, scale and emit steps in order;
// all phases use the single shared multiplier. A sample item holds the input until
// its last phase is emitted; a coefficient item does not stall the input.
// The next sample is taken while the last result still waits in the output register.
// Reset clears history (per-entry valid bits), pointer, residue and registers at once;
// the coefficient store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module polyphase_rational_resampler import prr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [31:0] sample,
	input  wire logic [11:0] coef_index,
	input  wire logic [23:0] coef_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      out_sample,
	output logic             clipped,
	output logic             last
);
	prr_cmd_t  cmd;
	prr_stat_t stat;

	prr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .kind(kind), .in_ready(in_ready),
		.cmd(cmd), .stat(stat)
	);

	prr_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .sample(sample),
		.coef_index(coef_index), .coef_value(coef_value), .out_sample(out_sample),
		.clipped(clipped), .last(last), .out_valid(out_valid), .out_ready(out_ready)
	);
endmodule
`default_nettype wire

// ===== sv/prr_ctrl.sv =====
// Controller: configuration registers, phase sequencing and tap counting.
`timescale 1ns / 1ps
`default_nettype none
module prr_ctrl import prr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        kind,
	output logic             in_ready,
	output prr_cmd_t         cmd,
	input  prr_stat_t        stat
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_MAC   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_MAG   = 3'd4;
	localparam logic [2:0] ST_SCALE = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]  state_q, state_d;
	logic [6:0]  up_q, down_q;
	logic [8:0]  taps_q;
	logic [15:0] skip_rem_q;
	logic [7:0]  res_q;
	logic [8:0]  tcnt_q;
	logic [6:0]  ell, em;
	logic [8:0]  taps;
	logic [7:0]  r_next;
	logic        accept;

	always_comb begin
		ell = (up_q == 7'd0) ? 7'd1 : ((up_q > 7'(MAX_UP)) ? 7'(MAX_UP) : up_q);
		em = (down_q == 7'd0) ? 7'd1 : down_q;
		taps = (taps_q > 9'(HIST_DEPTH)) ? 9'(HIST_DEPTH) : taps_q;
		r_next = res_q + {1'b0, em};
		accept = in_valid && in_ready;
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.ell = ell;
		cmd.phase = res_q;
		cmd.coef_wr = accept && kind;
		cmd.hist_wr = accept && !kind;
		cmd.out_last = (r_next >= {1'b0, ell});
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !kind) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (res_q < {1'b0, ell}) begin
					cmd.start = 1'b1;
					state_d = (taps == 9'd0) ? ST_DRAIN : ST_MAC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
				if (tcnt_q == taps - 9'd1) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.busy) state_d = ST_MAG;
			end
			ST_MAG: begin
				cmd.fin_mag = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.fin_scale = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (skip_rem_q != 16'd0) begin
					state_d = ST_CHECK;
				end else if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_CHECK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			up_q <= 7'd1;
			down_q <= 7'd1;
			taps_q <= 9'd1;
			skip_rem_q <= 16'd0;
			res_q <= 8'd0;
			tcnt_q <= 9'd0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_UP:   up_q <= cfg_data[6:0];
					REG_DOWN: down_q <= cfg_data[6:0];
					REG_TAPS: taps_q <= cfg_data[8:0];
					REG_SKIP: skip_rem_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_CHECK) begin
				tcnt_q <= 9'd0;
				if (res_q >= {1'b0, ell}) res_q <= res_q - {1'b0, ell};
			end
			if (state_q == ST_MAC) tcnt_q <= tcnt_q + 9'd1;
			if (state_q == ST_EMIT) begin
				if (skip_rem_q != 16'd0) begin
					skip_rem_q <= skip_rem_q - 16'd1;
					res_q <= r_next;
				end else if (stat.out_free) begin
					res_q <= r_next;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/prr_dp.sv =====
// Datapath: coefficient and history memories, MAC pipeline, scaling and output register.
`timescale 1ns / 1ps
`default_nettype none
module prr_dp import prr_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  prr_cmd_t                     cmd,
	output prr_stat_t                    stat,
	input  wire logic [SAMPLE_WIDTH-1:0] sample,
	input  wire logic [COEF_AW-1:0]      coef_index,
	input  wire logic [COEF_WIDTH-1:0]   coef_value,
	output logic [SAMPLE_WIDTH-1:0]      out_sample,
	output logic                         clipped,
	output logic                         last,
	output logic                         out_valid,
	input  wire logic                    out_ready
);
	logic [COEF_WIDTH-1:0]   coef_mem [COEF_DEPTH];
	logic [SAMPLE_WIDTH-1:0] hist_mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0]   hvalid_q;
	logic [HIST_AW-1:0]      ptr_q, hidx_q, ptr_inc;
	logic [COEF_AW-1:0]      caddr_q;
	logic [COEF_WIDTH-1:0]   coef_s1;
	logic [SAMPLE_WIDTH-1:0] hist_s1;
	logic                    hv_s1, vld_s1, vld_s2;
	logic signed [55:0]      prod_s2;
	logic signed [SAMPLE_WIDTH-1:0] xs;
	logic signed [COEF_WIDTH-1:0]   cs;
	logic [ACC_WIDTH-1:0]    acc_q, mag_q;
	logic                    neg_q;
	logic [70:0]             sc_full;
	logic [47:0]             total_q;
	logic [SAMPLE_WIDTH-1:0] sat_val;
	logic                    sat_clip;
	logic [SAMPLE_WIDTH-1:0] out_q;
	logic                    clip_q, last_q, ovld_q;

	assign ptr_inc = ptr_q + 8'd1;
	assign xs = hv_s1 ? $signed(hist_s1) : '0;
	assign cs = $signed(coef_s1);
	assign sc_full = {7'd0, mag_q} * {64'd0, cmd.ell};

	always_comb begin
		if (!neg_q) begin
			sat_clip = (total_q > 48'h7FFF_FFFF);
			sat_val = sat_clip ? 32'h7FFF_FFFF : total_q[31:0];
		end else begin
			sat_clip = (total_q > 48'h8000_0000);
			sat_val = sat_clip ? 32'h8000_0000 : (~total_q[31:0] + 32'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.coef_wr) coef_mem[coef_index] <= coef_value;
		coef_s1 <= coef_mem[caddr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.hist_wr) hist_mem[ptr_inc] <= sample;
		hist_s1 <= hist_mem[hidx_q];
	end

	always_ff @(posedge clk) begin
		hv_s1 <= hvalid_q[hidx_q];
		prod_s2 <= xs * cs;
		if (cmd.start) begin
			caddr_q <= {4'd0, cmd.phase};
			hidx_q <= ptr_q;
		end else if (cmd.issue) begin
			caddr_q <= caddr_q + {5'd0, cmd.ell};
			hidx_q <= hidx_q - 8'd1;
		end
		if (cmd.start) acc_q <= '0;
		else if (vld_s2) acc_q <= acc_q + {{8{prod_s2[55]}}, prod_s2};
		if (cmd.fin_mag) begin
			neg_q <= acc_q[63];
			mag_q <= acc_q[63] ? (~acc_q + 64'd1) : acc_q;
		end
		if (cmd.fin_scale) total_q <= sc_full[70:23];
		if (cmd.load_out) begin
			out_q <= sat_val;
			clip_q <= sat_clip;
			last_q <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
			ptr_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (cmd.hist_wr) begin
				hvalid_q[ptr_inc] <= 1'b1;
				ptr_q <= ptr_inc;
			end
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			if (cmd.load_out) ovld_q <= 1'b1;
			else if (out_ready) ovld_q <= 1'b0;
		end
	end

	assign stat.busy = vld_s1 | vld_s2;
	assign stat.out_free = !ovld_q || out_ready;
	assign out_sample = out_q;
	assign clipped = clip_q;
	assign last = last_q;
	assign out_valid = ovld_q;
endmodule
`default_nettype wire

// ===== sv/prr_checker.sv =====
// Checker: port-level properties of the resampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module prr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        kind,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_sample,
	input wire logic        clipped
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample))
		else $error("result item changed while stalled");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !kind |=> !in_ready)
		else $error("sample item did not occupy the block");

	a_coef_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind |=> in_ready)
		else $error("coefficient item stalled the input");

	a_clip_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> out_sample == 32'h7FFF_FFFF || out_sample == 32'h8000_0000)
		else $error("clipped result not at a rail");
endmodule

bind polyphase_rational_resampler prr_checker u_prr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
	.out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample),
	.clipped(clipped)
);
`default_nettype wire

// ===== tb/tb_polyphase_rational_resampler.sv =====
// Testbench: polyphase rational resampler, self-checking against a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_polyphase_rational_resampler;
	import prr_pkg::*;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_COEF   = 1'b1;
	localparam int   CYCLE_LIMIT = 3000000;
	localparam int   COEF_USED   = 128;

	typedef struct {
		logic [31:0] value;
		logic        clip;
		logic        fin;
	} resamp_out_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [31:0] sample;
	logic [11:0] coef_index;
	logic [23:0] coef_value;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] out_sample;
	logic        clipped;
	logic        last;

	polyphase_rational_resampler uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .sample(sample), .coef_index(coef_index), .coef_value(coef_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_sample(out_sample), .clipped(clipped), .last(last)
	);

	// predictor state
	logic [31:0] hist_mem [HIST_DEPTH];
	logic [7:0]  hist_ptr;
	logic [23:0] coef_mem [COEF_DEPTH];
	int          residue;
	int          skip_left;
	int          up_reg, down_reg, taps_reg;
	resamp_out_t pending_q[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_cycles;
	int  mismatches;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver readiness
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles = hold_cycles - 1;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		resamp_out_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result %h clip %b last %b", out_sample, clipped, last);
			end else begin
				exp_r = pending_q.pop_front();
				if (exp_r.value !== out_sample || exp_r.clip !== clipped ||
						exp_r.fin !== last) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%b/%b got %h/%b/%b", exp_r.value,
							exp_r.clip, exp_r.fin, out_sample, clipped, last);
				end
			end
		end
	end

	function automatic int eff_up();
		int l;
		l = (up_reg == 0) ? 1 : up_reg;
		return (l > MAX_UP) ? MAX_UP : l;
	endfunction

	function automatic int eff_taps();
		return (taps_reg > HIST_DEPTH) ? HIST_DEPTH : taps_reg;
	endfunction

	function automatic void resample_step(logic [31:0] s);
		int ell, em, taps, r, n0;
		longint acc, x, c;
		logic [63:0] mag, total;
		logic neg;
		resamp_out_t res;
		hist_ptr = hist_ptr + 8'd1;
		hist_mem[hist_ptr] = s;
		ell = eff_up();
		em = (down_reg == 0) ? 1 : down_reg;
		taps = eff_taps();
		r = residue;
		n0 = pending_q.size();
		while (r < ell) begin
			acc = 0;
			for (int t = 0; t < taps; t++) begin
				x = longint'($signed(hist_mem[8'(hist_ptr - t)]));
				c = longint'($signed(coef_mem[(r + t * ell) % COEF_DEPTH]));
				acc = acc + x * c;
			end
			neg = acc[63];
			mag = neg ? -acc : acc;
			total = (mag >> 23) * ell + (((mag & 64'h7FFFFF) * ell) >> 23);
			res.clip = 1'b0;
			res.fin = 1'b0;
			if (!neg) begin
				if (total > 64'h7FFFFFFF) begin
					res.clip = 1'b1;
					res.value = 32'h7FFFFFFF;
				end else res.value = total[31:0];
			end else begin
				if (total > 64'h80000000) begin
					res.clip = 1'b1;
					res.value = 32'h80000000;
				end else res.value = 32'(-total);
			end
			if (skip_left > 0) skip_left = skip_left - 1;
			else pending_q.push_back(res);
			r = r + em;
		end
		residue = (r - ell) & 255;
		if (pending_q.size() > n0) pending_q[pending_q.size() - 1].fin = 1'b1;
	endfunction

	task automatic send_item(logic k, logic [31:0] s, logic [11:0] ci, logic [23:0] cv);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		kind = k;
		sample = s;
		coef_index = ci;
		coef_value = cv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (k == KIND_COEF) coef_mem[ci] = cv;
		else resample_step(s);
	endtask

	task automatic send_sample(logic [31:0] s);
		send_item(KIND_SAMPLE, s, 12'($urandom), 24'($urandom));
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(200)) - 100);
			default: return $urandom;
		endcase
	endfunction

	task automatic drain();
		int wait_cycles;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		wait_cycles = eff_up() * (eff_taps() + 7) + 20;
		repeat (wait_cycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = 16'(val);
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_UP:   up_reg = val & 8'h7F;
			REG_DOWN: down_reg = val & 8'h7F;
			REG_TAPS: taps_reg = val & 16'h1FF;
			REG_SKIP: skip_left = val & 16'hFFFF;
			default: ;
		endcase
	endtask

	task automatic configure(int up, int down, int taps, int skip);
		drain();
		write_reg(REG_UP, up);
		write_reg(REG_DOWN, down);
		write_reg(REG_TAPS, taps);
		write_reg(REG_SKIP, skip);
	endtask

	// every configuration below reads only addresses under COEF_USED
	task automatic test_coef_table();
		for (int a = 0; a < COEF_USED; a++)
			send_item(KIND_COEF, $urandom, 12'(a), 24'($urandom));
	endtask

	task automatic test_directed();
		configure(3, 2, 4, 0);
		send_sample(32'h7FFFFFFF);
		send_sample(32'h80000000);
		send_sample(32'h0);
		send_sample(32'hFFFFFFFF);
		for (int a = 0; a < 12; a++) send_item(KIND_COEF, 32'h0, 12'(a), 24'h7FFFFF);
		repeat (4) send_sample(32'h7FFFFFFF);
		repeat (4) send_sample(32'h80000000);
		send_item(KIND_COEF, 32'h0, 12'hFFF, 24'h800000);
		send_item(KIND_COEF, 32'h0, 12'h000, 24'h800000);
		send_sample(32'h12345678);
		configure(0, 0, 0, 0);
		send_sample(rand_sample());
		send_sample(rand_sample());
		configure(64, 1, 2, 0);
		send_sample(rand_sample());
		configure(5, 3, 3, 0);
		send_sample(rand_sample());
		send_sample(rand_sample());
		configure(127, 127, 2, 0);
		repeat (3) send_sample(rand_sample());
		configure(64, 64, 2, 0);
		send_sample(rand_sample());
		configure(4, 1, 2, 5);
		repeat (3) send_sample(rand_sample());
		configure(2, 1, 1, 65535);
		repeat (2) send_sample(rand_sample());
		configure(2, 1, 1, 0);
	endtask

	task automatic test_random(int n, int sidle, int ridle);
		configure($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(16, 1), 0);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15)
				send_item(KIND_COEF, $urandom, 12'($urandom), 24'($urandom));
			else
				send_sample(rand_sample());
		end
	endtask

	task automatic test_backpressure();
		configure(4, 1, 4, 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 3000;
		repeat (20) send_sample(rand_sample());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_UP;
		cfg_data = 16'h0;
		in_valid = 1'b0;
		kind = KIND_SAMPLE;
		sample = 32'h0;
		coef_index = 12'h0;
		coef_value = 24'h0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		mismatches = 0;
		cycles = 0;
		for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = 32'h0;
		for (int i = 0; i < COEF_DEPTH; i++) coef_mem[i] = 24'h0;
		hist_ptr = 8'h0;
		residue = 0;
		skip_left = 0;
		up_reg = 1;
		down_reg = 1;
		taps_reg = 1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_coef_table();
		test_directed();
		test_random(30, 24, 49);
		test_random(30, 49, 24);
		test_random(31, 0, 0);
		test_backpressure();

		drain();
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
